### rtl/core/rpt_pkg.sv
// Shared types, widths and codes of the rigid point transform pipeline.
`timescale 1ns / 1ps

package rpt_pkg;

    // Field and datapath widths.
    localparam int COORD_W    = 32;
    localparam int COORD_FRAC = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = COEF_W - 2;
    localparam int OPER_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * OPER_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int DIST_W     = 2 * COORD_W;
    localparam int OP_W       = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int IN_DATA_W  = 3 * COORD_W;
    localparam int OUT_DATA_W = 3 * COORD_W + DIST_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ROW_T    = 3'd0;
    localparam logic [OP_W-1:0] OP_ROW      = 3'd1;
    localparam logic [OP_W-1:0] OP_COL      = 3'd2;
    localparam logic [OP_W-1:0] OP_COL_DIFF = 3'd3;
    localparam logic [OP_W-1:0] OP_DIST     = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_ROW0 = 3'd0;
    localparam logic [2:0] REG_ROW1 = 3'd1;
    localparam logic [2:0] REG_ROW2 = 3'd2;
    localparam logic [2:0] REG_TX   = 3'd3;
    localparam logic [2:0] REG_TY   = 3'd4;
    localparam logic [2:0] REG_TZ   = 3'd5;

    // Matrix (m[r][j] is row r, entry j) and translation.
    typedef struct packed {
        logic [2:0][2:0][COEF_W-1:0] m;
        logic [2:0][COORD_W-1:0]     t;
    } cfg_t;

    // Multiplier operands for lane (i, j).
    typedef struct packed {
        logic [OP_W-1:0]             op;
        logic [2:0][2:0][OPER_W-1:0] a;
        logic [2:0][2:0][OPER_W-1:0] b;
        logic [2:0][COORD_W-1:0]     t;
    } oper_t;

    // Products of the nine lanes.
    typedef struct packed {
        logic [OP_W-1:0]             op;
        logic [2:0][2:0][PROD_W-1:0] prod;
        logic [2:0][COORD_W-1:0]     t;
    } prod_t;

    // Exact sums, one for each output coordinate.
    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [2:0][ACC_W-1:0]  acc;
    } sum_t;

    // Finished result item.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] xyz;
        logic [DIST_W-1:0]       dist_sq;
        logic                    sat;
    } res_t;

endpackage

### rtl/core/rpt_cfg_regs.sv
// APB-style configuration registers holding the matrix and translation.
`timescale 1ns / 1ps

module rpt_cfg_regs import rpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;

    logic [2:0][2:0][COEF_W-1:0] m_reg;
    logic [2:0][COORD_W-1:0]     t_reg;
    logic [2:0]                  idx;
    logic                        wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[CFG_ADDR_W-1:3];
    assign wr_en  = psel & penable & pwrite & pready;

    // Register writes; reset loads the identity matrix and a zero translation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg[0] <= {{(2*COEF_W){1'b0}}, COEF_ONE};
            m_reg[1] <= {{COEF_W{1'b0}}, COEF_ONE, {COEF_W{1'b0}}};
            m_reg[2] <= {COEF_ONE, {(2*COEF_W){1'b0}}};
            t_reg    <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ROW0: m_reg[0] <= pwdata[3*COEF_W-1:0];
                REG_ROW1: m_reg[1] <= pwdata[3*COEF_W-1:0];
                REG_ROW2: m_reg[2] <= pwdata[3*COEF_W-1:0];
                REG_TX:   t_reg[0] <= pwdata[COORD_W-1:0];
                REG_TY:   t_reg[1] <= pwdata[COORD_W-1:0];
                REG_TZ:   t_reg[2] <= pwdata[COORD_W-1:0];
                default:  ;
            endcase
        end
    end

    // Read-back of the addressed register.
    always_comb
    begin
        unique case (idx)
            REG_ROW0: prdata = CFG_DATA_W'(m_reg[0]);
            REG_ROW1: prdata = CFG_DATA_W'(m_reg[1]);
            REG_ROW2: prdata = CFG_DATA_W'(m_reg[2]);
            REG_TX:   prdata = CFG_DATA_W'(t_reg[0]);
            REG_TY:   prdata = CFG_DATA_W'(t_reg[1]);
            REG_TZ:   prdata = CFG_DATA_W'(t_reg[2]);
            default:  prdata = '0;
        endcase
    end

    assign cfg.m = m_reg;
    assign cfg.t = t_reg;

endmodule

### rtl/core/rpt_oper_sel.sv
// Pipeline stage 1: routes point, differences and matrix entries to the lanes.
`timescale 1ns / 1ps

module rpt_oper_sel import rpt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [OP_W-1:0]      op,
    input  logic [IN_DATA_W-1:0] point,
    input  cfg_t                 cfg,
    output logic                 out_valid,
    output oper_t                out_data
);

    logic                        valid_reg;
    oper_t                       data_reg;
    oper_t                       data_next;
    logic [2:0][OPER_W-1:0]      pe;
    logic [2:0][OPER_W-1:0]      te;
    logic [2:0][2:0][OPER_W-1:0] ce;

    // Sign-extend point, translation and coefficients to the operand width.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            pe[j] = {{(OPER_W-COORD_W){point[COORD_W*j+COORD_W-1]}},
                     point[COORD_W*j +: COORD_W]};
            te[j] = {{(OPER_W-COORD_W){cfg.t[j][COORD_W-1]}}, cfg.t[j]};
            for (int i = 0; i < 3; i++)
            begin
                ce[i][j] = {{(OPER_W-COEF_W){cfg.m[i][j][COEF_W-1]}}, cfg.m[i][j]};
            end
        end
    end

    // Lane (i, j) feeds output coordinate i with term j.
    always_comb
    begin
        data_next    = '0;
        data_next.op = op;
        data_next.t  = cfg.t;
        unique case (op)
            OP_ROW_T, OP_ROW:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        data_next.a[i][j] = pe[j];
                        data_next.b[i][j] = ce[j][i];
                    end
                end
            end
            OP_COL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        data_next.a[i][j] = pe[j];
                        data_next.b[i][j] = ce[i][j];
                    end
                end
            end
            OP_COL_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        data_next.a[i][j] = pe[j] - te[j];
                        data_next.b[i][j] = ce[i][j];
                    end
                end
            end
            OP_DIST:
            begin
                // The squares use the first row of lanes only.
                for (int j = 0; j < 3; j++)
                begin
                    data_next.a[0][j] = te[j] - pe[j];
                    data_next.b[0][j] = te[j] - pe[j];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/rpt_mul_array.sv
// Pipeline stage 2: nine signed multipliers, one for each lane.
`timescale 1ns / 1ps

module rpt_mul_array import rpt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  oper_t in_data,
    output logic  out_valid,
    output prod_t out_data
);

    logic  valid_reg;
    prod_t data_reg;
    prod_t data_next;

    // Full-precision products of the lane operands.
    always_comb
    begin
        data_next.op = in_data.op;
        data_next.t  = in_data.t;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                data_next.prod[i][j] = PROD_W'($signed(in_data.a[i][j])
                                               * $signed(in_data.b[i][j]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/rpt_sum.sv
// Pipeline stage 3: exact sum of the three products and, for OP_ROW_T, the translation term.
`timescale 1ns / 1ps

module rpt_sum import rpt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  prod_t in_data,
    output logic  out_valid,
    output sum_t  out_data
);

    logic                     valid_reg;
    sum_t                     data_reg;
    sum_t                     data_next;
    logic [2:0][2:0][ACC_W-1:0] pext;
    logic [2:0][ACC_W-1:0]    tterm;

    // Widen the products; the translation enters with the coefficient scale.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pext[i][j] = {{(ACC_W-PROD_W){in_data.prod[i][j][PROD_W-1]}},
                              in_data.prod[i][j]};
            end
            if (in_data.op == OP_ROW_T)
            begin
                tterm[i] = {{(ACC_W-COORD_W){in_data.t[i][COORD_W-1]}}, in_data.t[i]}
                           << COEF_FRAC;
            end
            else
            begin
                tterm[i] = '0;
            end
        end
    end

    always_comb
    begin
        data_next.op = in_data.op;
        for (int i = 0; i < 3; i++)
        begin
            data_next.acc[i] = pext[i][0] + pext[i][1] + pext[i][2] + tterm[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // A distance sum is a sum of squares and lives in the first lane alone.
    a_dist_lane: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && data_reg.op == OP_DIST) |->
        (data_reg.acc[1] == '0 && data_reg.acc[2] == '0 && !data_reg.acc[0][ACC_W-1]))
        else $error("distance sum spread outside the first lane or negative");

endmodule

### rtl/core/rpt_round_sat.sv
// Pipeline stage 4: rounding, saturation and the output register.
`timescale 1ns / 1ps

module rpt_round_sat import rpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  sum_t in_data,
    output logic out_valid,
    output res_t out_data
);

    localparam logic [ACC_W-1:0]   HALF    = ACC_W'(1) << (COEF_FRAC - 1);
    localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic                    valid_reg;
    res_t                    data_reg;
    res_t                    data_next;
    logic [2:0][ACC_W-1:0]   sh;
    logic [2:0][COORD_W-1:0] clamped;
    logic [2:0]              ovf;
    logic                    dist_ovf;

    // Round to nearest with ties upward, then clamp to the coordinate range.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sh[i]  = ACC_W'($signed(in_data.acc[i] + HALF) >>> COEF_FRAC);
            ovf[i] = !((&sh[i][ACC_W-1:COORD_W-1]) || !(|sh[i][ACC_W-1:COORD_W-1]));
            if (ovf[i])
            begin
                clamped[i] = sh[i][ACC_W-1] ? NEG_MIN : POS_MAX;
            end
            else
            begin
                clamped[i] = sh[i][COORD_W-1:0];
            end
        end
        dist_ovf = |in_data.acc[0][ACC_W-1:DIST_W];
    end

    // Select the fields that the operation defines; the rest stay zero.
    always_comb
    begin
        data_next = '0;
        unique case (in_data.op)
            OP_ROW_T, OP_ROW, OP_COL, OP_COL_DIFF:
            begin
                data_next.xyz = clamped;
                data_next.sat = |ovf;
            end
            OP_DIST:
            begin
                data_next.dist_sq = dist_ovf ? '1 : in_data.acc[0][DIST_W-1:0];
                data_next.sat     = dist_ovf;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // A distance result never comes with a transformed point.
    a_dist_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && data_reg.dist_sq != '0) |-> (data_reg.xyz == '0))
        else $error("distance and transformed point both non-zero");

    // The flag is only raised together with a clamped value.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && data_reg.sat) |->
        (data_reg.dist_sq == '1 ||
         data_reg.xyz[0] == POS_MAX || data_reg.xyz[0] == NEG_MIN ||
         data_reg.xyz[1] == POS_MAX || data_reg.xyz[1] == NEG_MIN ||
         data_reg.xyz[2] == POS_MAX || data_reg.xyz[2] == NEG_MIN))
        else $error("saturation flag without a clamped result");

endmodule

### rtl/core/rigid_point_transform.sv
// Top level of the rigid point transform: configuration port and pipeline.
`timescale 1ns / 1ps

// Channel   Direction  Width        Contents
// s_*       in         96 + 3 user  point px, py, pz; op in tuser
// m_*       out        160 + 1 user out_x, out_y, out_z, dist_sq; saturated in tuser
// APB       in/out     64 data      matrix rows at 0x00..0x10, translation 0x18..0x28
//
// One item is accepted per cycle while the output is not stalled, and its result
// reaches the output through four register stages.
// The four stages are operand routing, nine 33x33 multipliers, the exact sum
// and rounding with saturation into the output register.
// Each stage holds its item while the next one is full and held, so a stalled
// output fills empty stages before input is held off; nothing is lost or repeated.
// Reset clears all valid bits and loads the identity matrix with zero translation.

module rigid_point_transform import rpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input items.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // px, py, pz
    input  logic [OP_W-1:0]       s_tuser,   // op
    // Result items.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_x, out_y, out_z, dist_sq
    output logic                  m_tuser,   // saturated
    // Configuration.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t  cfg;
    oper_t s1_data;
    prod_t s2_data;
    sum_t  s3_data;
    res_t  s4_data;
    logic  s1_valid;
    logic  s2_valid;
    logic  s3_valid;
    logic  s4_valid;
    logic  en1;
    logic  en2;
    logic  en3;
    logic  en4;

    // A stage loads when it is empty or when the stage after it moves on.
    assign en4      = !s4_valid || m_tready;
    assign en3      = !s3_valid || en4;
    assign en2      = !s2_valid || en3;
    assign en1      = !s1_valid || en2;
    assign s_tready = en1;

    rpt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rpt_oper_sel u_oper (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en1),
        .in_valid  (s_tvalid),
        .op        (s_tuser),
        .point     (s_tdata),
        .cfg       (cfg),
        .out_valid (s1_valid),
        .out_data  (s1_data)
    );

    rpt_mul_array u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en2),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_data  (s2_data)
    );

    rpt_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en3),
        .in_valid  (s2_valid),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_data  (s3_data)
    );

    rpt_round_sat u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en4),
        .in_valid  (s3_valid),
        .in_data   (s3_data),
        .out_valid (s4_valid),
        .out_data  (s4_data)
    );

    assign m_tvalid = s4_valid;
    assign m_tdata  = {s4_data.dist_sq, s4_data.xyz[2], s4_data.xyz[1], s4_data.xyz[0]};
    assign m_tuser  = s4_data.sat;

    // Input is held off only when every stage is full behind a stalled output.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid && s2_valid && s3_valid && s4_valid && !m_tready))
        else $error("input held off while the pipeline has room");

endmodule

### tb/point_checker.sv
// Checker of the rigid point transform: predicts every result item and compares.
`timescale 1ns / 1ps

module point_checker import rpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // px, py, pz
    input  logic [OP_W-1:0]       s_tuser,   // op
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // out_x, out_y, out_z, dist_sq
    input  logic                  m_tuser,   // saturated
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    mismatches,
    output int                    pending_items
);

    localparam int REPORT_LINES = 100;
    localparam logic signed [79:0] COORD_MAX = 80'sd2147483647;
    localparam logic signed [79:0] COORD_MIN = -80'sd2147483648;
    localparam logic signed [79:0] ROUND_HALF = 80'sd1 <<< (COEF_FRAC - 1);

    // Shadow copy of the matrix rows and the translation.
    logic [3*COEF_W-1:0] mrow [3];
    logic [COORD_W-1:0]  trans [3];

    res_t expected_points [$];
    int   results_seen;

    // Works out the result item of one point under the current shadow setup.
    function automatic res_t transform_point(input logic [OP_W-1:0] op,
                                             input logic [COORD_W-1:0] px,
                                             input logic [COORD_W-1:0] py,
                                             input logic [COORD_W-1:0] pz);
        logic signed [79:0] pv [3];
        logic signed [79:0] tv [3];
        logic signed [79:0] cf [3][3];
        logic signed [79:0] acc;
        logic signed [79:0] rnd;
        logic signed [79:0] d;
        logic signed [79:0] dsum;
        res_t r;
        pv[0] = $signed(px);
        pv[1] = $signed(py);
        pv[2] = $signed(pz);
        for (int i = 0; i < 3; i++)
        begin
            tv[i] = $signed(trans[i]);
            for (int j = 0; j < 3; j++)
                cf[i][j] = $signed(mrow[i][COEF_W*j +: COEF_W]);
        end
        r = '0;
        if (op <= OP_COL_DIFF)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc = '0;
                for (int j = 0; j < 3; j++)
                begin
                    case (op)
                        OP_ROW_T, OP_ROW: acc = acc + pv[j] * cf[j][i];
                        OP_COL:           acc = acc + cf[i][j] * pv[j];
                        default:          acc = acc + cf[i][j] * (pv[j] - tv[j]);
                    endcase
                end
                // The translation joins the exact sum before the one rounding.
                if (op == OP_ROW_T)
                    acc = acc + (tv[i] <<< COEF_FRAC);
                rnd = (acc + ROUND_HALF) >>> COEF_FRAC;
                if (rnd > COORD_MAX)
                begin
                    r.xyz[i] = COORD_MAX[COORD_W-1:0];
                    r.sat = 1'b1;
                end
                else if (rnd < COORD_MIN)
                begin
                    r.xyz[i] = COORD_MIN[COORD_W-1:0];
                    r.sat = 1'b1;
                end
                else
                    r.xyz[i] = rnd[COORD_W-1:0];
            end
        end
        else if (op == OP_DIST)
        begin
            dsum = '0;
            for (int i = 0; i < 3; i++)
            begin
                d = tv[i] - pv[i];
                dsum = dsum + d * d;
            end
            if (dsum[79:DIST_W] != '0)
            begin
                r.dist_sq = '1;
                r.sat = 1'b1;
            end
            else
                r.dist_sq = dsum[DIST_W-1:0];
        end
        return r;
    endfunction

    // Counts a mismatch and prints a line for each of the first REPORT_LINES of them.
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LINES)
            $display("mismatch: %s", msg);
    endtask

    initial
    begin
        mismatches = 0;
        pending_items = 0;
        results_seen = 0;
    end

    // Watch both channels and the configuration port.
    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_r;
        res_t got_r;
        if (!rst_n)
        begin
            mrow[0] = 48'h0000_0000_4000;
            mrow[1] = 48'h0000_4000_0000;
            mrow[2] = 48'h4000_0000_0000;
            for (int i = 0; i < 3; i++)
                trans[i] = '0;
            expected_points.delete();
            pending_items = 0;
        end
        else
        begin
            // Result items are checked against the oldest expectation.
            if (m_tvalid && m_tready)
            begin
                got_r.xyz[0]  = m_tdata[COORD_W-1:0];
                got_r.xyz[1]  = m_tdata[2*COORD_W-1:COORD_W];
                got_r.xyz[2]  = m_tdata[3*COORD_W-1:2*COORD_W];
                got_r.dist_sq = m_tdata[3*COORD_W +: DIST_W];
                got_r.sat     = m_tuser;
                if (expected_points.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                else
                begin
                    exp_r = expected_points.pop_front();
                    for (int i = 0; i < 3; i++)
                        if (got_r.xyz[i] !== exp_r.xyz[i])
                            report_mismatch($sformatf("result %0d coord %0d got %h expected %h",
                                                      results_seen, i, got_r.xyz[i],
                                                      exp_r.xyz[i]));
                    if (got_r.dist_sq !== exp_r.dist_sq)
                        report_mismatch($sformatf("result %0d dist_sq got %h expected %h",
                                                  results_seen, got_r.dist_sq,
                                                  exp_r.dist_sq));
                    if (got_r.sat !== exp_r.sat)
                        report_mismatch($sformatf("result %0d saturated got %b expected %b",
                                                  results_seen, got_r.sat, exp_r.sat));
                end
                results_seen++;
            end
            // Every accepted point produces exactly one result item.
            if (s_tvalid && s_tready)
                expected_points.push_back(transform_point(s_tuser,
                                                          s_tdata[COORD_W-1:0],
                                                          s_tdata[2*COORD_W-1:COORD_W],
                                                          s_tdata[3*COORD_W-1:2*COORD_W]));
            // Register writes land in the shadow setup; unmapped indexes are dropped.
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[CFG_ADDR_W-1:3])
                    REG_ROW0: mrow[0]  = pwdata[3*COEF_W-1:0];
                    REG_ROW1: mrow[1]  = pwdata[3*COEF_W-1:0];
                    REG_ROW2: mrow[2]  = pwdata[3*COEF_W-1:0];
                    REG_TX:   trans[0] = pwdata[COORD_W-1:0];
                    REG_TY:   trans[1] = pwdata[COORD_W-1:0];
                    REG_TZ:   trans[2] = pwdata[COORD_W-1:0];
                    default: ;
                endcase
            end
            pending_items = expected_points.size();
        end
    end

endmodule

### tb/testbench.sv
// Top of the rigid point transform testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import rpt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_STALL = 60;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS = 210;
    localparam logic [2:0] UNMAPPED_LO = 3'd6;
    localparam logic [2:0] UNMAPPED_HI = 3'd7;
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
    localparam logic [COORD_W-1:0] C_MAX = 32'h7fff_ffff;
    localparam logic [COORD_W-1:0] C_MIN = 32'h8000_0000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // px, py, pz
    logic [OP_W-1:0]       s_tuser;   // op
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // out_x, out_y, out_z, dist_sq
    logic                  m_tuser;   // saturated
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int pending_items;
    int cycle_count;
    bit src_idle_on;
    bit sink_idle_on;
    bit long_stall_req;

    rigid_point_transform uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    point_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .pending_items (pending_items)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Guard against a hung run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Result side: random hold-off bursts, plus one long stall on request.
    initial
    begin
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_stall_req)
            begin
                hold = LONG_STALL;
                long_stall_req = 1'b0;
            end
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else if (sink_idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                hold = $urandom_range(0, 3);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Coordinates: full range, small and medium magnitudes, and the extremes.
    function automatic logic [COORD_W-1:0] rand_coord();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 3))
            0: return v;
            1: return {{12{v[19]}}, v[19:0]};
            2: return {{4{v[27]}}, v[27:0]};
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return '0;
                    3: return 32'h0001_0000;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    // Offers one point, after an optional gap, and waits for it to be taken.
    task automatic send_point(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] px,
                              input logic [COORD_W-1:0] py, input logic [COORD_W-1:0] pz);
        @(negedge clk);
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pz, py, px};
        do @(posedge clk); while (!s_tready);
    endtask

    // One register write: setup cycle, then access until pready.
    task automatic write_register(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stops offering points and waits until every expected result is back.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_items != 0)
            @(posedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [3*COEF_W-1:0] row;
        logic [31:0] v;
        logic [OP_W-1:0] op;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        src_idle_on    = 1'b1;
        sink_idle_on   = 1'b1;
        long_stall_req = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset setup: every op code, including the unused ones, and the extremes.
        for (int k = 0; k <= OP_UNUSED_LAST; k++)
            send_point(OP_W'(k), 32'h0001_8000, 32'hfffe_4000, 32'h0000_2001);
        send_point(OP_DIST, C_MIN, C_MIN, C_MIN);
        send_point(OP_ROW_T, C_MAX, C_MIN, '0);

        // Largest positive coefficients and translation: clamping on the translated-row, difference and distance paths.
        drain_results();
        for (int r = 0; r < 3; r++)
            write_register(3'(REG_ROW0 + r), {16'ha5a5, 48'h7fff_7fff_7fff});
        write_register(REG_TX, {32'hffff_ffff, C_MAX});
        write_register(REG_TY, {32'hffff_ffff, C_MAX});
        write_register(REG_TZ, {32'hffff_ffff, C_MAX});
        write_register(UNMAPPED_LO, {$urandom(), $urandom()});
        write_register(UNMAPPED_HI, {$urandom(), $urandom()});
        send_point(OP_ROW_T, C_MAX, C_MAX, C_MAX);
        send_point(OP_COL_DIFF, C_MIN, C_MIN, C_MIN);
        send_point(OP_DIST, C_MIN, C_MIN, C_MIN);
        send_point(OP_COL, C_MAX, C_MIN, '0);

        // Most negative coefficients and translation.
        drain_results();
        for (int r = 0; r < 3; r++)
            write_register(3'(REG_ROW0 + r), {16'h5a5a, 48'h8000_8000_8000});
        write_register(REG_TX, {32'h1234_5678, C_MIN});
        write_register(REG_TY, {32'h1234_5678, C_MIN});
        write_register(REG_TZ, {32'h1234_5678, C_MIN});
        send_point(OP_ROW, C_MIN, C_MIN, C_MIN);
        send_point(OP_ROW_T, C_MAX, C_MAX, C_MAX);
        send_point(OP_DIST, C_MAX, C_MAX, C_MAX);
        send_point(OP_COL_DIFF, C_MAX, '0, C_MIN);

        // Smallest coefficient on the diagonal: ties round towards plus infinity.
        drain_results();
        write_register(REG_ROW0, 64'h0000_0000_0000_0001);
        write_register(REG_ROW1, 64'h0000_0000_0001_0000);
        write_register(REG_ROW2, 64'h0000_0001_0000_0000);
        write_register(REG_TX, 64'h0000_0000_0000_0001);
        write_register(REG_TY, 64'h0000_0000_ffff_ffff);
        write_register(REG_TZ, 64'h0000_0000_0000_0000);
        send_point(OP_ROW, 32'h0000_2000, 32'hffff_e000, 32'h0000_6000);
        send_point(OP_COL, 32'hffff_a000, 32'h0000_1fff, 32'hffff_dfff);
        send_point(OP_ROW_T, 32'h0000_2000, 32'hffff_e000, 32'h0000_1fff);

        // Random setups, each followed by a run of random points.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            src_idle_on  = (phase != 2) && (phase != RANDOM_PHASES - 1);
            sink_idle_on = (phase != 1) && (phase != RANDOM_PHASES - 1);
            for (int r = 0; r < 3; r++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    v = $urandom();
                    if ($urandom_range(0, 2) == 0)
                        row[COEF_W*j +: COEF_W] = v[15:0];
                    else
                        row[COEF_W*j +: COEF_W] = {v[14], v[14:0]};
                end
                v = $urandom();
                write_register(3'(REG_ROW0 + r), {v[15:0], row});
            end
            write_register(REG_TX, {$urandom(), rand_coord()});
            write_register(REG_TY, {$urandom(), rand_coord()});
            write_register(REG_TZ, {$urandom(), rand_coord()});
            if ($urandom_range(0, 1) == 0)
                write_register(UNMAPPED_HI, {$urandom(), $urandom()});
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // One long hold-off on the result side while points keep coming.
                if (phase == 3 && n == 40)
                    long_stall_req = 1'b1;
                if ($urandom_range(0, 15) == 0)
                    op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
                else
                    op = OP_W'($urandom_range(OP_ROW_T, OP_DIST));
                send_point(op, rand_coord(), rand_coord(), rand_coord());
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_items == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
